### hw/rtl/bhre_pkg.sv
`timescale 1ns / 1ps

package bhre_pkg;

  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned CfgWidth   = 16;

  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [CfgWidth-1:0] DebounceReset     = 16'd0;
  localparam logic                PressedLevelReset = 1'b0;
  localparam logic [CfgWidth-1:0] HoldIntervalReset = 16'd1000;
  localparam logic [CfgWidth-1:0] RepeatWindowReset = 16'd500;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_PRESSED_LEVEL = 2'd1,
    REG_HOLD_INTERVAL = 2'd2,
    REG_REPEAT_WINDOW = 2'd3
  } bhre_reg_t;

  typedef enum logic {
    EV_PRESS_OR_HOLD = 1'b0,
    EV_RELEASE       = 1'b1
  } bhre_event_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_time;
    logic                pressed_level;
    logic [CfgWidth-1:0] hold_period;
    logic [CfgWidth-1:0] repeat_window;
  } bhre_cfg_t;

  typedef struct packed {
    logic [TimeWidth-1:0]  time_now;
    logic [TimeWidth-1:0]  last_event_time;
    logic [TimeWidth-1:0]  press_start_time;
    logic                  press_timing_valid;
    logic [TimeWidth-1:0]  release_stamp;
    logic                  release_valid;
    logic                  is_pressed;
    logic [CountWidth-1:0] hold_counter;
    logic [CountWidth-1:0] repeat_counter;
  } bhre_state_t;

  typedef struct packed {
    bhre_event_t           event_kind;
    logic [CountWidth-1:0] hold_count;
    logic [CountWidth-1:0] repeat_count;
  } bhre_result_t;

endpackage

### hw/rtl/bhre_step.sv
`timescale 1ns / 1ps

module bhre_step (
  input  bhre_pkg::bhre_state_t  state_i,
  input  bhre_pkg::bhre_cfg_t    cfg_i,
  input  logic                   pin_level_i,
  output bhre_pkg::bhre_state_t  state_nxt_o,
  output logic                   res_valid_o,
  output bhre_pkg::bhre_result_t res_o
);
  import bhre_pkg::*;

  logic [TimeWidth-1:0] t_now;
  logic [TimeWidth-1:0] since_event;
  logic [TimeWidth-1:0] since_press;
  logic [TimeWidth-1:0] since_release;
  logic                 down;
  logic                 ignored;
  logic                 hold_due;
  logic                 quick_repeat;

  assign t_now         = state_i.time_now + TimeWidth'(1);
  assign since_event   = t_now - state_i.last_event_time;
  assign since_press   = t_now - state_i.press_start_time;
  assign since_release = t_now - state_i.release_stamp;
  assign down          = (pin_level_i == cfg_i.pressed_level);
  assign ignored       = since_event < TimeWidth'(cfg_i.debounce_time);
  assign hold_due      = state_i.press_timing_valid &&
                         (since_press >= TimeWidth'(cfg_i.hold_period));
  assign quick_repeat  = since_release <= TimeWidth'(cfg_i.repeat_window);

  always_comb begin
    state_nxt_o          = state_i;
    state_nxt_o.time_now = t_now;
    res_valid_o          = 1'b0;
    res_o.event_kind     = EV_PRESS_OR_HOLD;
    res_o.hold_count     = state_i.hold_counter;
    res_o.repeat_count   = state_i.repeat_counter;
    priority if (ignored) begin
    end else if (state_i.is_pressed && !down) begin
      state_nxt_o.press_timing_valid = 1'b0;
      state_nxt_o.release_stamp      = t_now;
      state_nxt_o.release_valid      = 1'b1;
      state_nxt_o.is_pressed         = 1'b0;
      state_nxt_o.hold_counter       = '0;
      state_nxt_o.last_event_time    = t_now;
      res_valid_o                    = 1'b1;
      res_o.event_kind               = EV_RELEASE;
    end else if (state_i.is_pressed && hold_due) begin
      if (state_i.hold_counter < CountMax) begin
        state_nxt_o.press_start_time = t_now;
        state_nxt_o.hold_counter     = state_i.hold_counter + CountWidth'(1);
      end else begin
        state_nxt_o.press_timing_valid = 1'b0;
      end
      state_nxt_o.last_event_time = t_now;
      res_valid_o                 = 1'b1;
      res_o.hold_count            = state_nxt_o.hold_counter;
    end else if (!state_i.is_pressed && down) begin
      state_nxt_o.press_start_time   = t_now;
      state_nxt_o.press_timing_valid = 1'b1;
      state_nxt_o.is_pressed         = 1'b1;
      if (state_i.release_valid) begin
        if (quick_repeat) begin
          if (state_i.repeat_counter < CountMax) begin
            state_nxt_o.repeat_counter = state_i.repeat_counter + CountWidth'(1);
          end
        end else begin
          state_nxt_o.repeat_counter = '0;
        end
        state_nxt_o.release_valid = 1'b0;
      end
      state_nxt_o.last_event_time = t_now;
      res_valid_o                 = 1'b1;
      res_o.repeat_count          = state_nxt_o.repeat_counter;
    end else begin
    end
  end

endmodule

### hw/rtl/button_hold_repeat_events_core.sv
`timescale 1ns / 1ps
// Button event generator: debounce, press, periodic hold and release events.
// The input channel takes one beat per millisecond tick carrying the sampled
// pin level; the result channel delivers zero or one event beat per tick.
// A tick is accepted in every cycle while the two-entry output buffer has
// room, so the sustained rate is one tick per cycle. The state update and the
// event decision for a tick are made in the cycle it is accepted, and its
// event beat is registered into the output register or the skid entry.
// When the receiver stalls, one further event beat is held in a skid entry;
// while that entry is full the input is not ready. Ticks that raise no event
// are still accepted as long as room remains.
// Configuration is written through the cfg_ port at any edge with cfg_we high,
// and should only be changed while the block is idle.
// A synchronous active-low reset clears the time base, the press and release
// tracking and both counters, empties the output buffer and loads the
// register defaults: debounce 0, pressed level 0, hold interval 1000 ms and
// repeat window 500 ms.
module button_hold_repeat_events_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bhre_pkg::CfgWidth-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pin_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_event_kind,
  output logic [7:0]                    out_hold_count,
  output logic [7:0]                    out_repeat_count
);
  import bhre_pkg::*;

  bhre_cfg_t    cfg_r;
  bhre_state_t  state_r;
  bhre_state_t  state_nxt;
  logic         res_valid;
  bhre_result_t res;
  logic         out_valid_r;
  bhre_result_t out_r;
  logic         skid_valid_r;
  bhre_result_t skid_r;
  logic         in_fire;
  logic         out_fire;
  logic         new_res;

  bhre_step u_step (
    .state_i     (state_r),
    .cfg_i       (cfg_r),
    .pin_level_i (in_pin_level),
    .state_nxt_o (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign new_res  = in_fire && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DebounceReset;
      cfg_r.pressed_level <= PressedLevelReset;
      cfg_r.hold_period   <= HoldIntervalReset;
      cfg_r.repeat_window <= RepeatWindowReset;
    end else if (cfg_we) begin
      unique case (bhre_reg_t'(cfg_index))
        REG_DEBOUNCE_TIME: cfg_r.debounce_time <= cfg_wdata;
        REG_PRESSED_LEVEL: cfg_r.pressed_level <= cfg_wdata[0];
        REG_HOLD_INTERVAL: cfg_r.hold_period   <= cfg_wdata;
        REG_REPEAT_WINDOW: cfg_r.repeat_window <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_ready) begin
      if (new_res) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (out_valid_r && !out_ready) begin
      if (new_res) begin
        skid_r <= res;
      end
    end else if (new_res) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_r.event_kind;
  assign out_hold_count   = out_r.hold_count;
  assign out_repeat_count = out_r.repeat_count;

endmodule

### tb/tb_button_hold_repeat_events_core.sv
`timescale 1ns / 1ps

module tb_button_hold_repeat_events_core;
  import bhre_pkg::*;

  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_pin_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_event_kind;
  logic [7:0]  out_hold_count;
  logic [7:0]  out_repeat_count;

  button_hold_repeat_events_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_hold_count   (out_hold_count),
    .out_repeat_count (out_repeat_count)
  );

  always #2 clk = ~clk;

  // Mirror of the configuration registers.
  logic [15:0] m_debounce = DebounceReset;
  logic        m_level = PressedLevelReset;
  logic [15:0] m_hold_iv = HoldIntervalReset;
  logic [15:0] m_window = RepeatWindowReset;

  // Button tracking state of the predictor.
  logic [31:0] now_ms = '0;
  logic [31:0] last_ev_ms = '0;
  logic [31:0] press_ms = '0;
  logic [31:0] rel_ms = '0;
  logic        press_timed = 1'b0;
  logic        rel_seen = 1'b0;
  logic        held = 1'b0;
  logic [7:0]  hold_cnt = '0;
  logic [7:0]  rep_cnt = '0;

  logic         pin_q[$];
  bhre_result_t button_events_q[$];

  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Advances the button tracker by one millisecond tick and queues any event.
  task automatic track_button_tick(input logic pin);
    logic         down;
    logic         fire;
    bhre_result_t ev;
    down = (pin == m_level);
    fire = 1'b0;
    ev = '0;
    now_ms = now_ms + 32'd1;
    if ((now_ms - last_ev_ms) >= 32'(m_debounce)) begin
      if (held) begin
        if (!down) begin
          press_timed = 1'b0;
          rel_ms = now_ms;
          rel_seen = 1'b1;
          held = 1'b0;
          ev = '{event_kind: EV_RELEASE, hold_count: hold_cnt, repeat_count: rep_cnt};
          fire = 1'b1;
          hold_cnt = '0;
        end else if (press_timed && (now_ms - press_ms) >= 32'(m_hold_iv)) begin
          if (hold_cnt != CountMax) begin
            press_ms = now_ms;
            hold_cnt = hold_cnt + 8'd1;
          end else begin
            press_timed = 1'b0;
          end
          ev = '{event_kind: EV_PRESS_OR_HOLD, hold_count: hold_cnt, repeat_count: rep_cnt};
          fire = 1'b1;
        end
      end else if (down) begin
        press_ms = now_ms;
        press_timed = 1'b1;
        held = 1'b1;
        if (rel_seen) begin
          if ((now_ms - rel_ms) <= 32'(m_window)) begin
            if (rep_cnt != CountMax) rep_cnt = rep_cnt + 8'd1;
          end else begin
            rep_cnt = '0;
          end
          rel_seen = 1'b0;
        end
        ev = '{event_kind: EV_PRESS_OR_HOLD, hold_count: hold_cnt, repeat_count: rep_cnt};
        fire = 1'b1;
      end
    end
    if (fire) begin
      last_ev_ms = now_ms;
      button_events_q.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pin_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pin_level <= pin_q.pop_front();
        if (!calm && $urandom_range(0, 99) < in_idle_pct) gap_left = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < out_idle_pct) stall_left = $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin
    bhre_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) track_button_tick(in_pin_level);
      if (out_valid && out_ready) begin
        if (button_events_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d hold %0d repeat %0d",
                                    out_event_kind, out_hold_count, out_repeat_count));
        end else begin
          want = button_events_q.pop_front();
          if (out_event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d",
                                      out_event_kind, want.event_kind));
          if (out_hold_count !== want.hold_count)
            report_mismatch($sformatf("hold_count %0d, expected %0d",
                                      out_hold_count, want.hold_count));
          if (out_repeat_count !== want.repeat_count)
            report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                      out_repeat_count, want.repeat_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained;
    do @(posedge clk);
    while (pin_q.size() != 0 || in_valid || button_events_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] debounce, input logic level,
                                input logic [15:0] hold_iv, input logic [15:0] window,
                                input int in_pct, input int out_pct);
    wait_drained();
    m_debounce = debounce;
    m_level = level;
    m_hold_iv = hold_iv;
    m_window = window;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE_TIME;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_index <= REG_PRESSED_LEVEL;
    cfg_wdata <= {15'($urandom), level};
    @(posedge clk);
    cfg_index <= REG_HOLD_INTERVAL;
    cfg_wdata <= hold_iv;
    @(posedge clk);
    cfg_index <= REG_REPEAT_WINDOW;
    cfg_wdata <= window;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_level(input logic pin, input int count);
    repeat (count) pin_q.push_back(pin);
  endtask

  // Alternating press and release runs of random length, with stray samples.
  task automatic queue_runs(input int n, input int max_on, input int max_off,
                            input int noise_pct);
    int total;
    int len;
    total = 0;
    while (total < n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pin_q.push_back(1'($urandom));
        total++;
      end
      len = $urandom_range(1, max_on);
      queue_level(m_level, len);
      total += len;
      len = $urandom_range(1, max_off);
      queue_level(!m_level, len);
      total += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The first ticks after reset fall inside the debounce time.
    apply_settings(16'd3, 1'b1, 16'd2, 16'd4, 0, 0);
    queue_level(1'b1, 8);
    queue_level(1'b0, 4);
    queue_level(1'b1, 3);
    queue_level(1'b0, 1);

    // A zero hold interval and a zero repeat window.
    apply_settings(16'd0, 1'b0, 16'd0, 16'd0, 20, 20);
    queue_level(1'b1, 3);
    queue_level(1'b0, 1);
    queue_level(1'b1, 2);
    queue_level(1'b0, 2);

    apply_settings(DebounceReset, PressedLevelReset, HoldIntervalReset, RepeatWindowReset,
                   15, 15);
    queue_runs(60, 30, 30, 10);

    apply_settings(16'd0, 1'b1, 16'd3, 16'd5, 10, 25);
    queue_runs(100, 20, 10, 10);

    apply_settings(16'd2, 1'b0, 16'd5, 16'd8, 25, 10);
    queue_runs(100, 30, 15, 15);

    // Fast clicking drives the repeat count into saturation.
    apply_settings(16'd0, 1'b1, 16'd1, 16'hFFFF, 5, 5);
    queue_runs(540, 1, 1, 0);

    // A long press drives the hold count into saturation.
    apply_settings(16'd0, 1'b0, 16'd1, 16'd3, 10, 10);
    queue_level(1'b1, 3);
    queue_level(1'b0, 300);
    queue_level(1'b1, 2);

    apply_settings(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 20, 20);
    queue_runs(40, 5, 5, 20);

    apply_settings(16'd1, 1'b0, 16'd0, 16'hFFFF, 15, 30);
    queue_runs(60, 6, 4, 10);

    apply_settings(16'($urandom_range(0, 4)), 1'($urandom), 16'($urandom_range(1, 12)),
                   16'($urandom_range(0, 20)), 0, 0);
    calm = 1'b1;
    queue_runs(120, 15, 15, 10);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bhre_pkg.sv
hw/rtl/bhre_step.sv
hw/rtl/button_hold_repeat_events_core.sv
tb/tb_button_hold_repeat_events_core.sv
